/* design/assert_macros.svh */
// Shared assertion macros for the message FIFO block.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/mfow_pkg.sv */
`timescale 1ns / 1ps

package mfow_pkg;

    // Widths fixed by the port fields.
    localparam int FIELD_W   = 13;
    localparam int LIMIT_W   = 14;
    localparam int PAYLOAD_W = 64;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // Limit saturates here and doubling stops.
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 14'd16383;

    // Reset value of the overload base and limit.
    localparam logic [FIELD_W-1:0] OVERLOAD_RESET = 13'd1024;

    // Register index of the overload base.
    localparam logic [ADDR_W-3:0] REG_OVERLOAD_BASE = 1'b0;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_TAKE    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

/* design/mfow_ram.sv */
`timescale 1ns / 1ps

module mfow_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/message_fifo_overload_watch.sv */
`timescale 1ns / 1ps
// The result beat is registered and on the output ports in the cycle after start is taken.
// Throughput: one operation per cycle; busy never rises, the ring memory is
// read and written by different operations, so back-to-back push and pop need no stall.
// Reset (rst_n low, asynchronous) empties the ring, sets the limit and base to 1024,
// sets the scheduled flag and clears the release flag; the ring memory is not cleared.
// Results cannot be stalled: each beat is valid for the single cycle that done is high.

`include "assert_macros.svh"

module message_fifo_overload_watch #(
    parameter int DEPTH     = 4096,
    parameter int MSG_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Command side
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           opcode,
    input  logic [mfow_pkg::PAYLOAD_W-1:0]       msg_in,
    // Result side
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [mfow_pkg::PAYLOAD_W-1:0]       msg_out,
    output logic [mfow_pkg::FIELD_W-1:0]         fill_count,
    output logic [mfow_pkg::FIELD_W-1:0]         overload_value,
    output logic                                 schedule_req,
    output logic                                 release_marked,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mfow_pkg::ADDR_W-1:0]          paddr,
    input  logic [mfow_pkg::DATA_W-1:0]          pwdata,
    output logic [mfow_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > mfow_pkg::LIMIT_W) ? CNT_W : mfow_pkg::LIMIT_W;
    localparam int SHF_W = 2 * mfow_pkg::LIMIT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // State
    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [PTR_W-1:0]                 tail_reg, tail_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [mfow_pkg::LIMIT_W-1:0]     limit_reg, limit_next;
    logic [CNT_W-1:0]                 seen_reg, seen_next;
    logic                             sched_flag_reg, sched_flag_next;
    logic                             rel_flag_reg, rel_flag_next;
    logic [mfow_pkg::FIELD_W-1:0]     base_reg;

    // Result registers
    logic                             done_reg;
    mfow_pkg::status_t                status_reg, status_next;
    logic [mfow_pkg::FIELD_W-1:0]     ovl_reg, ovl_next;
    logic                             sreq_reg, sreq_next;
    logic                             pop_hit_reg, pop_hit_next;

    // Memory and decode
    logic                             accept;
    logic                             ram_wr_en;
    logic                             ram_rd_en;
    logic [MSG_WIDTH-1:0]             ram_rd_data;
    logic                             cfg_write;
    logic [CNT_W-1:0]                 count_dec;
    logic [mfow_pkg::LIMIT_W-1:0]     limit_floor;
    logic [mfow_pkg::LIMIT_W-1:0]     limit_grown;
    logic [mfow_pkg::LIMIT_W-1:0]     base_eff;
    logic [SHF_W-1:0]                 shifted;
    logic [mfow_pkg::LIMIT_W-1:0]     cand;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // Configuration register write and read-back.
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= mfow_pkg::OVERLOAD_RESET;
        end
        else if (cfg_write && (paddr[mfow_pkg::ADDR_W-1:2] == mfow_pkg::REG_OVERLOAD_BASE))
        begin
            base_reg <= pwdata[mfow_pkg::FIELD_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[mfow_pkg::ADDR_W-1:2] == mfow_pkg::REG_OVERLOAD_BASE)
        begin
            prdata = mfow_pkg::DATA_W'(base_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // A base of zero behaves as one.
    assign base_eff = (base_reg == '0) ? mfow_pkg::LIMIT_W'(1)
                                       : mfow_pkg::LIMIT_W'(base_reg);

    // Watermark after a pop: the first saturated doubling of the limit that
    // reaches the remaining length, or the saturation value if none does.
    assign count_dec   = count_reg - CNT_W'(1);
    assign limit_floor = (limit_reg == '0) ? mfow_pkg::LIMIT_W'(1) : limit_reg;

    always_comb
    begin
        limit_grown = mfow_pkg::LIMIT_MAX;
        shifted     = '0;
        cand        = '0;
        for (int k = mfow_pkg::LIMIT_W; k >= 1; k--)
        begin
            shifted = SHF_W'(limit_floor) << k;
            if (shifted > SHF_W'(mfow_pkg::LIMIT_MAX))
            begin
                cand = mfow_pkg::LIMIT_MAX;
            end
            else
            begin
                cand = shifted[mfow_pkg::LIMIT_W-1:0];
            end
            if (CMP_W'(cand) >= CMP_W'(count_dec))
            begin
                limit_grown = cand;
            end
        end
    end

    // Operation decode: next state and the result fields.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        limit_next      = limit_reg;
        seen_next       = seen_reg;
        sched_flag_next = sched_flag_reg;
        rel_flag_next   = rel_flag_reg;
        status_next     = mfow_pkg::ST_OK;
        ovl_next        = '0;
        sreq_next       = 1'b0;
        pop_hit_next    = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        if (accept)
        begin
            case (mfow_pkg::op_t'(opcode))
                mfow_pkg::OP_PUSH:
                begin
                    if (count_reg == CNT_FULL)
                    begin
                        status_next = mfow_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_wr_en       = 1'b1;
                        tail_next       = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                        count_next      = count_reg + CNT_W'(1);
                        sched_flag_next = 1'b1;
                        sreq_next       = !sched_flag_reg;
                    end
                end
                mfow_pkg::OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next     = mfow_pkg::ST_EMPTY;
                        limit_next      = base_eff;
                        sched_flag_next = 1'b0;
                    end
                    else
                    begin
                        ram_rd_en    = 1'b1;
                        pop_hit_next = 1'b1;
                        head_next    = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
                        count_next   = count_dec;
                        if (CMP_W'(count_dec) > CMP_W'(limit_floor))
                        begin
                            seen_next  = count_dec;
                            limit_next = limit_grown;
                        end
                        else
                        begin
                            limit_next = limit_floor;
                        end
                    end
                end
                mfow_pkg::OP_TAKE:
                begin
                    ovl_next  = mfow_pkg::FIELD_W'(seen_reg);
                    seen_next = '0;
                end
                mfow_pkg::OP_RELEASE:
                begin
                    rel_flag_next = 1'b1;
                    sreq_next     = !sched_flag_reg;
                end
                default:
                begin
                    status_next = mfow_pkg::ST_OK;
                end
            endcase
        end
    end

    // Control state and result beat registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            limit_reg      <= mfow_pkg::LIMIT_W'(mfow_pkg::OVERLOAD_RESET);
            seen_reg       <= '0;
            sched_flag_reg <= 1'b1;
            rel_flag_reg   <= 1'b0;
            done_reg       <= 1'b0;
            pop_hit_reg    <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            limit_reg      <= limit_next;
            seen_reg       <= seen_next;
            sched_flag_reg <= sched_flag_next;
            rel_flag_reg   <= rel_flag_next;
            done_reg       <= accept;
            pop_hit_reg    <= pop_hit_next;
        end
    end

    // Payload of the result beat needs no reset.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ovl_reg    <= ovl_next;
        sreq_reg   <= sreq_next;
    end

    // Ring storage.
    mfow_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (msg_in[MSG_WIDTH-1:0]),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // Result ports; count and release flag already hold the post-operation values.
    assign done           = done_reg;
    assign status         = status_reg;
    assign msg_out        = pop_hit_reg ? mfow_pkg::PAYLOAD_W'(ram_rd_data) : '0;
    assign fill_count     = mfow_pkg::FIELD_W'(count_reg);
    assign overload_value = ovl_reg;
    assign schedule_req   = sreq_reg;
    assign release_marked = rel_flag_reg;

    // Assertions
    `CHECK_NEXT(a_done_follows_accept, accept, done)
    `CHECK_SAME(a_count_bound, 1'b1, count_reg <= CNT_FULL)
    `CHECK_SAME(a_ptrs_meet, (count_reg == '0) || (count_reg == CNT_FULL), head_reg == tail_reg)
    `CHECK_SAME(a_empty_beat, done && (status == mfow_pkg::ST_EMPTY), (msg_out == '0) && (count_reg == '0))
    `CHECK_SAME(a_limit_nonzero, 1'b1, limit_reg != '0)

endmodule
